// ----- design/arxs_pkg.sv -----
`timescale 1ns / 1ps
// arxs_pkg: shared widths, request codes and the MAC control bundle
// for the ARX model simulator. No dependencies.
package arxs_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 18;
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  localparam int FRAC_W   = 14;
  localparam int IDX_W    = 4;
  localparam int REG_W    = 4;
  localparam int OP_W     = 2;
  localparam int CFG_IDX_W = 2;

  // request opcodes
  localparam logic [OP_W-1:0] OP_SIM  = 2'd0;
  localparam logic [OP_W-1:0] OP_WR_A = 2'd1;
  localparam logic [OP_W-1:0] OP_WR_B = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ORDER_A     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER_B     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_DELAY = 2'd2;

  localparam logic [REG_W-1:0] ORDER_RST = 4'd0;
  localparam logic [REG_W-1:0] DELAY_RST = 4'd1;

  typedef struct packed {
    logic vld;  // operands valid this cycle
    logic sub;  // subtract the product (autoregressive tap)
    logic clr;  // start of a new sum
  } mac_ctrl_t;

endpackage

// ----- design/arxs_mac.sv -----
`timescale 1ns / 1ps
// arxs_mac: shared multiply-accumulate unit, one product per cycle,
// registered product then add or subtract. Depends on arxs_pkg.
module arxs_mac #(
  parameter int ACC_W = 40
) (
  input  logic                               clk,
  input  logic                               rst,
  input  arxs_pkg::mac_ctrl_t                ctrl,
  input  logic signed [arxs_pkg::COEF_W-1:0]   coef,
  input  logic signed [arxs_pkg::SAMPLE_W-1:0] data,
  output logic signed [ACC_W-1:0]            acc,
  output logic                               busy
);

  logic                                  v_q;
  logic                                  sub_q;
  logic signed [arxs_pkg::PROD_W-1:0]    prod_q;
  logic signed [ACC_W-1:0]               prod_ext;

  assign prod_ext = {{(ACC_W - arxs_pkg::PROD_W){prod_q[arxs_pkg::PROD_W-1]}}, prod_q};
  assign busy = v_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_q <= 1'b0;
    end else begin
      v_q <= ctrl.vld;
    end
    prod_q <= coef * data;
    sub_q  <= ctrl.sub;
    if (ctrl.clr) begin
      acc <= '0;
    end else if (v_q) begin
      acc <= sub_q ? acc - prod_ext : acc + prod_ext;
    end
  end

endmodule

// ----- design/arx_model_simulator.sv -----
`timescale 1ns / 1ps
// ARX model simulator: y(t) = sum b_i*u(t-nk-i) - sum a_j*y(t-j), one shared MAC.
// A simulate request issues nb+1+na taps (nb, na clamped orders) to the single
// MAC, one tap per cycle, then rounds and saturates the sum in S_ROUND and
// presents it from S_OUT. in_ready is low meanwhile and rises with the result, so
// a new request is taken only once the last result is out.
// Reset: orders 0, input_delay 1, coefficients and histories read as zero.
module arx_model_simulator #(
  parameter int MAX_ORDER_A = 8,
  parameter int MAX_ORDER_B = 8,
  parameter int MAX_DELAY   = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [arxs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [arxs_pkg::REG_W-1:0]           cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [arxs_pkg::OP_W-1:0]            opcode,
  input  logic signed [arxs_pkg::SAMPLE_W-1:0] sample,
  input  logic [arxs_pkg::IDX_W-1:0]           coef_index,
  input  logic signed [arxs_pkg::COEF_W-1:0]   coef_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [arxs_pkg::SAMPLE_W-1:0] model_output,
  output logic                                 saturated
);

  localparam int UD    = MAX_ORDER_B + MAX_DELAY;
  localparam int BD    = MAX_ORDER_B + 1;
  localparam int SPAN  = MAX_ORDER_A + MAX_ORDER_B + MAX_DELAY + 2;
  localparam int CNT_W = ($clog2(SPAN) > arxs_pkg::REG_W ? $clog2(SPAN)
                                                          : arxs_pkg::REG_W) + 1;
  localparam int UA_W  = (UD > 1) ? $clog2(UD) : 1;
  localparam int AA_W  = (MAX_ORDER_A > 1) ? $clog2(MAX_ORDER_A) : 1;
  localparam int BA_W  = (BD > 1) ? $clog2(BD) : 1;
  localparam int ACC_W = arxs_pkg::PROD_W + $clog2(MAX_ORDER_A + MAX_ORDER_B + 2);
  localparam int R_W   = ACC_W - arxs_pkg::FRAC_W;
  localparam logic signed [R_W-1:0]   Y_MAX = R_W'(32767);
  localparam logic signed [R_W-1:0]   Y_MIN = -R_W'(32768);
  localparam logic signed [ACC_W-1:0] HALF  = ACC_W'(1 << (arxs_pkg::FRAC_W - 1));

  typedef enum logic [1:0] {S_IDLE, S_MAC, S_ROUND, S_OUT} state_t;

  state_t state;

  logic [arxs_pkg::REG_W-1:0] order_a;
  logic [arxs_pkg::REG_W-1:0] order_b;
  logic [arxs_pkg::REG_W-1:0] input_delay;

  // coefficient stores with per-entry valid bits
  logic signed [arxs_pkg::COEF_W-1:0] amem [MAX_ORDER_A];
  logic signed [arxs_pkg::COEF_W-1:0] bmem [BD];
  logic [MAX_ORDER_A-1:0]             avalid;
  logic [BD-1:0]                      bvalid;

  // input history ring with fill count; output history shift line
  logic signed [arxs_pkg::SAMPLE_W-1:0] umem [UD];
  logic [UA_W-1:0]                      head;
  logic [CNT_W-1:0]                     ufill;
  logic signed [arxs_pkg::SAMPLE_W-1:0] yh [MAX_ORDER_A];

  logic signed [arxs_pkg::SAMPLE_W-1:0] sample_q;
  logic [CNT_W-1:0]                     tcnt;
  logic [CNT_W-1:0]                     na, nb, nk, total, pos, jtap;
  logic [CNT_W:0]                       uring;
  logic                                 is_b, issue, accept, wr_out, push;
  logic [UA_W-1:0]                      uaddr, head_next;

  // operand read stage
  logic                                 v1, isa_q, aok_q, bok_q, uok_q;
  logic signed [arxs_pkg::COEF_W-1:0]   a_rd, b_rd;
  logic signed [arxs_pkg::SAMPLE_W-1:0] u_rd, y_rd;
  logic signed [arxs_pkg::COEF_W-1:0]   mac_coef;
  logic signed [arxs_pkg::SAMPLE_W-1:0] mac_data;

  arxs_pkg::mac_ctrl_t                  mac_ctrl;
  logic signed [ACC_W-1:0]              acc;
  logic                                 mac_busy;
  logic signed [ACC_W-1:0]              rsum;
  logic signed [R_W-1:0]                rval;
  logic signed [arxs_pkg::SAMPLE_W-1:0] y_q;
  logic                                 sat_q;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign wr_out   = (state == S_OUT) && (!out_valid || out_ready);
  assign push     = wr_out;

  always_comb begin
    na = (CNT_W'(order_a) > CNT_W'(MAX_ORDER_A)) ? CNT_W'(MAX_ORDER_A) : CNT_W'(order_a);
    nb = (CNT_W'(order_b) > CNT_W'(MAX_ORDER_B)) ? CNT_W'(MAX_ORDER_B) : CNT_W'(order_b);
    priority if (input_delay == '0) begin
      nk = CNT_W'(1);
    end else if (CNT_W'(input_delay) > CNT_W'(MAX_DELAY)) begin
      nk = CNT_W'(MAX_DELAY);
    end else begin
      nk = CNT_W'(input_delay);
    end
    total = nb + na + CNT_W'(1);
    is_b  = (tcnt <= nb);
    pos   = nk + tcnt - CNT_W'(1);
    jtap  = tcnt - nb - CNT_W'(1);
    // entry pos of the history sits pos places behind the newest sample
    uring = (CNT_W + 1)'(head) + (CNT_W + 1)'(UD) - {1'b0, pos};
    if (uring >= (CNT_W + 1)'(UD)) begin
      uring = uring - (CNT_W + 1)'(UD);
    end
    uaddr     = uring[UA_W-1:0];
    head_next = (head == UA_W'(UD - 1)) ? '0 : head + UA_W'(1);
    issue     = (state == S_MAC) && (tcnt < total);
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      order_a     <= arxs_pkg::ORDER_RST;
      order_b     <= arxs_pkg::ORDER_RST;
      input_delay <= arxs_pkg::DELAY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        arxs_pkg::REG_ORDER_A:     order_a     <= cfg_data;
        arxs_pkg::REG_ORDER_B:     order_b     <= cfg_data;
        arxs_pkg::REG_INPUT_DELAY: input_delay <= cfg_data;
        default: ;
      endcase
    end
  end

  // coefficient memories
  always_ff @(posedge clk) begin
    if (accept && opcode == arxs_pkg::OP_WR_A && coef_index != '0
        && CNT_W'(coef_index) <= CNT_W'(MAX_ORDER_A)) begin
      amem[AA_W'(coef_index - arxs_pkg::IDX_W'(1))] <= coef_value;
    end
    if (accept && opcode == arxs_pkg::OP_WR_B
        && CNT_W'(coef_index) <= CNT_W'(MAX_ORDER_B)) begin
      bmem[BA_W'(coef_index)] <= coef_value;
    end
    a_rd <= amem[jtap[AA_W-1:0]];
    b_rd <= bmem[tcnt[BA_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      avalid <= '0;
      bvalid <= '0;
    end else begin
      if (accept && opcode == arxs_pkg::OP_WR_A && coef_index != '0
          && CNT_W'(coef_index) <= CNT_W'(MAX_ORDER_A)) begin
        avalid[AA_W'(coef_index - arxs_pkg::IDX_W'(1))] <= 1'b1;
      end
      if (accept && opcode == arxs_pkg::OP_WR_B
          && CNT_W'(coef_index) <= CNT_W'(MAX_ORDER_B)) begin
        bvalid[BA_W'(coef_index)] <= 1'b1;
      end
    end
  end

  // input history ring
  always_ff @(posedge clk) begin
    if (push) begin
      umem[head_next] <= sample_q;
    end
    u_rd <= umem[uaddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      ufill <= '0;
    end else if (push) begin
      head <= head_next;
      if (ufill < CNT_W'(UD)) begin
        ufill <= ufill + CNT_W'(1);
      end
    end
  end

  // output history
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_ORDER_A; k++) begin
        yh[k] <= '0;
      end
    end else if (push) begin
      yh[0] <= y_q;
      for (int k = 1; k < MAX_ORDER_A; k++) begin
        yh[k] <= yh[k-1];
      end
    end
  end

  // operand read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= issue;
    end
    isa_q <= !is_b;
    aok_q <= avalid[jtap[AA_W-1:0]];
    bok_q <= bvalid[tcnt[BA_W-1:0]];
    uok_q <= (pos < ufill);
    y_rd  <= yh[jtap[AA_W-1:0]];
  end

  always_comb begin
    if (isa_q) begin
      mac_coef = aok_q ? a_rd : '0;
      mac_data = y_rd;
    end else begin
      mac_coef = bok_q ? b_rd : '0;
      mac_data = uok_q ? u_rd : '0;
    end
    mac_ctrl.vld = v1;
    mac_ctrl.sub = isa_q;
    mac_ctrl.clr = accept && (opcode == arxs_pkg::OP_SIM);
  end

  arxs_mac #(.ACC_W(ACC_W)) u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctrl (mac_ctrl),
    .coef (mac_coef),
    .data (mac_data),
    .acc  (acc),
    .busy (mac_busy)
  );

  // round half up then drop the fraction: arithmetic shift is a floor
  assign rsum = acc + HALF;
  assign rval = rsum[ACC_W-1:arxs_pkg::FRAC_W];

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tcnt      <= '0;
      out_valid <= 1'b0;
    end else begin
      // a new result loaded in the same cycle keeps valid high
      if (out_valid && out_ready && !wr_out) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && opcode == arxs_pkg::OP_SIM) begin
            sample_q <= sample;
            tcnt     <= '0;
            state    <= S_MAC;
          end
        end
        S_MAC: begin
          if (issue) begin
            tcnt <= tcnt + CNT_W'(1);
          end else if (!v1 && !mac_busy) begin
            state <= S_ROUND;
          end
        end
        S_ROUND: begin
          if (rval > Y_MAX) begin
            y_q   <= arxs_pkg::SAMPLE_W'(Y_MAX);
            sat_q <= 1'b1;
          end else if (rval < Y_MIN) begin
            y_q   <= arxs_pkg::SAMPLE_W'(Y_MIN);
            sat_q <= 1'b1;
          end else begin
            y_q   <= rval[arxs_pkg::SAMPLE_W-1:0];
            sat_q <= 1'b0;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (wr_out) begin
            model_output <= y_q;
            saturated    <= sat_q;
            out_valid    <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_result_from_out_state: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_OUT))
    else $error("result raised outside the output state");

  a_tap_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_MAC) |-> (tcnt <= total))
    else $error("tap counter ran past the tap total");

  a_clear_when_drained: assert property (@(posedge clk) disable iff (rst)
    mac_ctrl.clr |-> (!v1 && !mac_busy))
    else $error("accumulator cleared with products in flight");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    ufill <= CNT_W'(UD))
    else $error("input history fill count overflow");
`endif

endmodule
